// ===== hw/rtl/lgg_pkg.sv =====
// Shared constants, types and the life rule for the life grid block.
package lgg_pkg;

    localparam int MAX_ROWS_DEF    = 64;
    localparam int MAX_COLUMNS_DEF = 64;

    localparam int              CFG_W           = 7;
    localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 7'd64;

    // operation codes
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    // configuration register indexes
    localparam logic REG_GRID_ROWS    = 1'b0;
    localparam logic REG_GRID_COLUMNS = 1'b1;

    // B3/S23 neighbor counts
    localparam logic [3:0] KEEP_COUNT  = 4'd2;
    localparam logic [3:0] BIRTH_COUNT = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CELL,
        ST_ADV_FETCH,
        ST_ADV_LOAD,
        ST_ADV_SHIFT,
        ST_ADV_STORE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clear;  // zero the row window at the start of a generation
        logic load;   // move rows up one place, take the fetched row below
        logic step;   // one column of the serial pass
    } t_row_ctl;

    function automatic logic f_next_life(input logic alive, input logic [3:0] count);
        return (count == BIRTH_COUNT) || (alive && (count == KEEP_COUNT));
    endfunction

endpackage

// ===== hw/rtl/lgg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lgg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/lgg_row_engine.sv =====
// Bit-serial row engine: three rotating row registers and a 3x3 window, one column a cycle.
module lgg_row_engine import lgg_pkg::*; #(
    parameter int COLUMNS = MAX_COLUMNS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_row_ctl                       i_ctl,
    input  logic [COLUMNS-1:0]             i_row,
    input  logic [$clog2(COLUMNS+1)-1:0]   i_cols,
    output logic [COLUMNS-1:0]             o_fresh,
    output logic                           o_done
);

    localparam int KW = $clog2(COLUMNS+1);

    logic [COLUMNS-1:0] r_above, r_cur, r_below, r_fresh;
    logic [1:0]         r_wa, r_wc, r_wb;   // [1] column k-1, [0] column k-2
    logic [KW-1:0]      r_k;

    logic       w_run;
    logic       w_in_a, w_in_c, w_in_b;
    logic [3:0] w_count;
    logic       w_new;

    always_comb begin
        w_run   = (r_k != KW'(COLUMNS));
        w_in_a  = w_run & r_above[0];
        w_in_c  = w_run & r_cur[0];
        w_in_b  = w_run & r_below[0];
        w_count = 4'(w_in_a) + 4'(r_wa[1]) + 4'(r_wa[0])
                + 4'(w_in_c) + 4'(r_wc[0])
                + 4'(w_in_b) + 4'(r_wb[1]) + 4'(r_wb[0]);
        // cell k-1 is evaluated; columns past the size in use stay dead
        w_new   = f_next_life(r_wc[1], w_count) && (r_k <= i_cols);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_ctl.clear || i_ctl.load) begin
            r_k <= '0;
        end else if (i_ctl.step && w_run) begin
            r_k <= r_k + KW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_above <= '0;
            r_cur   <= '0;
            r_below <= '0;
        end else if (i_ctl.load) begin
            r_above <= r_cur;
            r_cur   <= r_below;
            r_below <= i_row;
            r_wa    <= '0;
            r_wc    <= '0;
            r_wb    <= '0;
        end else if (i_ctl.step) begin
            if (w_run) begin
                // full rotation: rows are back in place once every column has been shifted through
                r_above <= {r_above[0], r_above[COLUMNS-1:1]};
                r_cur   <= {r_cur[0],   r_cur[COLUMNS-1:1]};
                r_below <= {r_below[0], r_below[COLUMNS-1:1]};
                r_wa    <= {w_in_a, r_wa[1]};
                r_wc    <= {w_in_c, r_wc[1]};
                r_wb    <= {w_in_b, r_wb[1]};
            end
            if (r_k != '0) begin
                r_fresh <= {w_new, r_fresh[COLUMNS-1:1]};
            end
        end
    end

    assign o_fresh = r_fresh;
    assign o_done  = i_ctl.step && !w_run;

endmodule

// ===== hw/rtl/life_grid_generation_step.sv =====
// Top level of the bounded B3/S23 life grid: command channel, grid RAM and row sequencer.
//
// Usage:
//  - Input channel (i_in_valid/o_in_ready) takes one command beat: write a cell, read a
//    cell, or advance the grid by one generation. Output channel (o_out_valid/i_out_ready)
//    returns exactly one beat per command: o_cell_out (read data) and o_range_error.
//  - One command is worked at a time. Steps from accept to o_out_valid:
//      cell read/write in range ........ RAM read, modify/write, result
//      out-of-range access, code 3 ..... result
//      advance ......................... fetch, load, column walk and store for each row
//    in use, then the result. The row engine walks each row word one column per cycle.
//  - The result sits in an output register; the next command is taken while it waits.
//    A stalled receiver holds a finished command until the register frees up.
//  - Reset (synchronous, active low) sets both size registers to 64 and marks every row
//    word invalid; an invalid row reads as all dead, so the grid comes up clear at once.
//  - Size registers are written through i_cfg_we/i_cfg_index/i_cfg_data with the block idle.
//
module life_grid_generation_step import lgg_pkg::*; #(
    parameter int MAX_ROWS    = MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    // command beats
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_operation,
    input  logic [5:0]       i_row_index,
    input  logic [5:0]       i_column_index,
    input  logic             i_cell_in,
    // result beats
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_cell_out,
    output logic             o_range_error
);

    localparam int ROW_AW = $clog2(MAX_ROWS);
    localparam int ROW_CW = $clog2(MAX_ROWS+1);
    localparam int COL_AW = $clog2(MAX_COLUMNS);
    localparam int COL_CW = $clog2(MAX_COLUMNS+1);

    // control state
    t_state                r_state, n_state;
    logic [CFG_W-1:0]      r_grid_rows, r_grid_columns;
    logic [MAX_ROWS-1:0]   r_row_valid;      // row words written since reset
    logic [ROW_CW-1:0]     r_fetch;          // row being fetched; row r_fetch-1 is in work
    logic                  r_out_valid;

    // latched command and results
    logic [1:0]            r_op;
    logic [5:0]            r_row;
    logic [5:0]            r_col;
    logic                  r_val;
    logic                  r_res_cell, r_res_err;
    logic                  r_cell_out, r_range_error;
    logic                  r_rd_valid;       // valid bit of the row just read
    logic [MAX_COLUMNS-1:0] r_cur_full, r_below_full;  // unmasked old words for write-back

    // size in use, clipped to the parameters
    logic [ROW_CW-1:0]     w_rows;
    logic [COL_CW-1:0]     w_cols;
    logic [MAX_COLUMNS-1:0] w_mask;

    logic                  w_in_accept, w_out_free;
    logic                  w_cell_op, w_range_err;

    // RAM ports
    logic                  w_re, w_we;
    logic [ROW_AW-1:0]     w_raddr, w_waddr;
    logic [MAX_COLUMNS-1:0] w_wdata, w_rdata;

    logic [MAX_COLUMNS-1:0] w_old_word, w_cell_word, w_fetch_full;

    t_row_ctl              w_ctl;
    logic [MAX_COLUMNS-1:0] w_fresh;
    logic                  w_row_done;

    always_comb begin
        w_rows = (32'(r_grid_rows) > 32'(MAX_ROWS)) ? ROW_CW'(MAX_ROWS)
                                                    : ROW_CW'(r_grid_rows);
        w_cols = (32'(r_grid_columns) > 32'(MAX_COLUMNS)) ? COL_CW'(MAX_COLUMNS)
                                                          : COL_CW'(r_grid_columns);
        for (int i = 0; i < MAX_COLUMNS; i++) begin
            w_mask[i] = (32'(i) < 32'(w_cols));
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_cell_op   = (i_operation == OP_WRITE) || (i_operation == OP_READ);
    assign w_range_err = (32'(i_row_index) >= 32'(w_rows))
                      || (32'(i_column_index) >= 32'(w_cols));

    // a never-written row reads as all dead
    always_comb begin
        w_old_word = r_rd_valid ? w_rdata : '0;
        for (int i = 0; i < MAX_COLUMNS; i++) begin
            w_cell_word[i] = (COL_AW'(r_col) == COL_AW'(i)) ? r_val : w_old_word[i];
        end
        w_fetch_full = ((32'(r_fetch) < 32'(w_rows)) && r_rd_valid) ? w_rdata : '0;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    unique case (i_operation)
                        OP_WRITE, OP_READ: n_state = w_range_err ? ST_DONE : ST_CELL;
                        OP_ADVANCE:        n_state = (w_rows == '0) ? ST_DONE : ST_ADV_FETCH;
                        default:           n_state = ST_DONE;
                    endcase
                end
            end
            ST_CELL:      n_state = ST_DONE;
            ST_ADV_FETCH: n_state = ST_ADV_LOAD;
            ST_ADV_LOAD:  n_state = (r_fetch == '0) ? ST_ADV_FETCH : ST_ADV_SHIFT;
            ST_ADV_SHIFT: n_state = w_row_done ? ST_ADV_STORE : ST_ADV_SHIFT;
            ST_ADV_STORE: n_state = (r_fetch == w_rows) ? ST_DONE : ST_ADV_FETCH;
            ST_DONE:      n_state = w_out_free ? ST_IDLE : ST_DONE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // RAM and row engine controls
    always_comb begin
        w_re    = 1'b0;
        w_raddr = '0;
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        w_ctl   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept && w_cell_op && !w_range_err) begin
                    w_re    = 1'b1;
                    w_raddr = ROW_AW'(i_row_index);
                end
                if (w_in_accept && (i_operation == OP_ADVANCE)) begin
                    w_ctl.clear = 1'b1;
                end
            end
            ST_CELL: begin
                if (r_op == OP_WRITE) begin
                    w_we    = 1'b1;
                    w_waddr = ROW_AW'(r_row);
                    w_wdata = w_cell_word;
                end
            end
            ST_ADV_FETCH: begin
                w_re    = 1'b1;
                w_raddr = ROW_AW'(r_fetch);
            end
            ST_ADV_LOAD: begin
                w_ctl.load = 1'b1;
            end
            ST_ADV_SHIFT: begin
                w_ctl.step = 1'b1;
            end
            ST_ADV_STORE: begin
                // cells past the column size keep their old contents
                w_we    = 1'b1;
                w_waddr = ROW_AW'(r_fetch - ROW_CW'(1));
                w_wdata = (r_cur_full & ~w_mask) | w_fresh;
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_grid_rows    <= GRID_SIZE_RESET;
            r_grid_columns <= GRID_SIZE_RESET;
            r_row_valid    <= '0;
            r_fetch        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_GRID_ROWS:    r_grid_rows    <= i_cfg_data;
                    REG_GRID_COLUMNS: r_grid_columns <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_we) begin
                r_row_valid[w_waddr] <= 1'b1;
            end
            priority if (w_in_accept) begin
                r_fetch <= '0;
            end else if ((r_state == ST_ADV_LOAD) && (r_fetch == '0)) begin
                r_fetch <= ROW_CW'(1);
            end else if ((r_state == ST_ADV_STORE) && (r_fetch != w_rows)) begin
                r_fetch <= r_fetch + ROW_CW'(1);
            end
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_op       <= i_operation;
            r_row      <= i_row_index;
            r_col      <= i_column_index;
            r_val      <= i_cell_in;
            r_res_cell <= 1'b0;
            r_res_err  <= w_cell_op && w_range_err;
        end else if ((r_state == ST_CELL) && (r_op == OP_READ)) begin
            r_res_cell <= w_old_word[COL_AW'(r_col)];
        end
        if (w_re) begin
            r_rd_valid <= r_row_valid[w_raddr];
        end
        if (w_ctl.clear) begin
            r_below_full <= '0;
        end else if (w_ctl.load) begin
            r_cur_full   <= r_below_full;
            r_below_full <= w_fetch_full;
        end
        if ((r_state == ST_DONE) && w_out_free) begin
            r_cell_out    <= r_res_cell;
            r_range_error <= r_res_err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cell_out    = r_cell_out;
    assign o_range_error = r_range_error;

    lgg_ram #(
        .WIDTH (MAX_COLUMNS),
        .DEPTH (MAX_ROWS)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    lgg_row_engine #(
        .COLUMNS (MAX_COLUMNS)
    ) u_row_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_row   (w_fetch_full & w_mask),
        .i_cols  (w_cols),
        .o_fresh (w_fresh),
        .o_done  (w_row_done)
    );

endmodule

// ===== hw/rtl/lgg_checker.sv =====
// Port-level assertions for the life grid block, bound to the top level.
module lgg_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_cell_out,
    input logic o_range_error
);

    // synchronous reset empties the output register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid right after reset");

    // one command at a time: an accepted beat closes the input side
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after an accepted beat");

    // a result beat never carries live cell data and a range error together
    a_data_or_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_cell_out && o_range_error))
        else $error("cell data and range error set together");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_cell_out) && $stable(o_range_error)))
        else $error("result beat changed while stalled");

endmodule

bind life_grid_generation_step lgg_checker u_lgg_checker (.*);

// ===== tb/life_grid_generation_step_test.sv =====
// Self-checking testbench for the bounded B3/S23 life grid: corners, sizes, blinker, stall, random generations.
module life_grid_generation_step_test;
    import lgg_pkg::*;

    // Code 3 is left unused by the block; it must come back as a clean, empty result.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int COMMAND_TARGET = 1250;
    localparam int RUN_LIMIT      = 4_000_000;  // time units
    localparam int SETTLE_CYCLES  = 20;
    localparam int HOLD_CYCLES    = 400;        // long receiver hold-off for the pressure test

    typedef struct packed {
        logic alive;    // o_cell_out
        logic flagged;  // o_range_error
    } t_cell_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic             i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [1:0]       i_operation;
    logic [5:0]       i_row_index;
    logic [5:0]       i_column_index;
    logic             i_cell_in;
    logic             o_out_valid;
    logic             i_out_ready;
    logic             o_cell_out;
    logic             o_range_error;

    life_grid_generation_step dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_row_index    (i_row_index),
        .i_column_index (i_column_index),
        .i_cell_in      (i_cell_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_cell_out     (o_cell_out),
        .o_range_error  (o_range_error)
    );

    // Grid model: one word per row, column c at bit c, plus the two size registers.
    logic [63:0]      grid_model [MAX_ROWS_DEF];
    logic [CFG_W-1:0] size_rows;
    logic [CFG_W-1:0] size_columns;

    // Results still owed by the block, oldest first.
    t_cell_result     pending_cell_results [$];

    int  failures;
    int  commands_sent;
    int  results_checked;
    int  generations_sent;
    int  flagged_expected;
    int  size_writes;
    int  burst_left;
    bit  hold_request;

    // Current random window: seeds and reads land here so live cells actually meet.
    int  win_r0, win_h, win_c0, win_w;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("Timeout at %0t with %0d results still owed", $time,
                 pending_cell_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Grid model
    // ------------------------------------------------------------------

    // Registers above the grid size are clipped to it.
    function automatic int rows_in_use();
        return (size_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(size_rows);
    endfunction

    function automatic int cols_in_use();
        return (size_columns > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : int'(size_columns);
    endfunction

    // Anything past the left or right border counts as dead: no wraparound.
    function automatic int live_at(logic [63:0] word, int c, int cols);
        if (c < 0 || c >= cols) return 0;
        return int'(word[c]);
    endfunction

    // One generation over the area in use, computed from the old rows only.
    // Bits outside the column mask and rows past the row count stay as they were.
    function automatic void advance_grid_model();
        int          rows, cols, n;
        logic [63:0] mask, above, here, below, fresh;
        rows  = rows_in_use();
        cols  = cols_in_use();
        mask  = (cols >= 64) ? '1 : ((64'd1 << cols) - 64'd1);
        above = '0;
        for (int r = 0; r < rows; r++) begin
            here  = grid_model[r] & mask;
            below = (r + 1 < rows) ? (grid_model[r + 1] & mask) : '0;
            fresh = '0;
            for (int c = 0; c < cols; c++) begin
                n = 0;
                for (int d = -1; d <= 1; d++) begin
                    n += live_at(above, c + d, cols) + live_at(below, c + d, cols);
                    if (d != 0) n += live_at(here, c + d, cols);
                end
                // birth on three, survival on two or three
                fresh[c] = (n == BIRTH_COUNT) || (here[c] && n == KEEP_COUNT);
            end
            grid_model[r] = (grid_model[r] & ~mask) | fresh;
            above = here;
        end
    endfunction

    // Applies one command to the model and returns the beat the block owes for it.
    function automatic t_cell_result apply_to_grid_model(logic [1:0] op, logic [5:0] row,
                                                         logic [5:0] col, logic value);
        t_cell_result res;
        res = '0;
        if (op == OP_WRITE || op == OP_READ) begin
            if (row >= rows_in_use() || col >= cols_in_use()) begin
                res.flagged = 1'b1;
            end else if (op == OP_WRITE) begin
                grid_model[row][col] = value;
            end else begin
                res.alive = grid_model[row][col];
            end
        end else if (op == OP_ADVANCE) begin
            advance_grid_model();
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Sends one command beat in the current burst. Between bursts valid drops for a
    // random gap; now and then a burst is long enough to give a stretch with no gaps.
    // Returns at the edge where the beat was taken; the expectation is queued there.
    task automatic send_command(input logic [1:0] op, input logic [5:0] row,
                                input logic [5:0] col, input logic value);
        int gap;
        t_cell_result res;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_row_index    <= row;
        i_column_index <= col;
        i_cell_in      <= value;
        do @(posedge i_clk); while (!o_in_ready);
        res = apply_to_grid_model(op, row, col, value);
        pending_cell_results.push_back(res);
        commands_sent++;
        if (op == OP_ADVANCE) generations_sent++;
        if (res.flagged) flagged_expected++;
    endtask

    // Every command yields exactly one beat, so an empty queue means the block is idle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_cell_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_size(input logic index, input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == REG_GRID_ROWS) size_rows = value;
        else                        size_columns = value;
        size_writes++;
        @(posedge i_clk);
    endtask

    function automatic void pick_window_cell(output logic [5:0] row, output logic [5:0] col);
        row = 6'(win_r0 + $urandom_range(0, win_h - 1));
        col = 6'(win_c0 + $urandom_range(0, win_w - 1));
    endfunction

    // Noise: the unused code, an address past the size in use, or a stray access.
    task automatic send_noise();
        int rows, cols;
        rows = rows_in_use();
        cols = cols_in_use();
        case ($urandom_range(0, 2))
            0: send_command(OP_UNUSED, 6'($urandom), 6'($urandom), 1'($urandom));
            1: begin
                if (rows < 64 && (cols == 64 || $urandom_range(0, 1) == 0)) begin
                    send_command(2'($urandom_range(0, 1)), 6'($urandom_range(rows, 63)),
                                 6'($urandom), 1'($urandom));
                end else if (cols < 64) begin
                    send_command(2'($urandom_range(0, 1)), 6'($urandom),
                                 6'($urandom_range(cols, 63)), 1'($urandom));
                end else begin
                    send_command(OP_READ, 6'($urandom), 6'($urandom), 1'($urandom));
                end
            end
            default: send_command(2'($urandom_range(0, 1)), 6'($urandom), 6'($urandom),
                                  1'($urandom));
        endcase
    endtask

    // Read or write inside the window, with an occasional noise beat mixed in.
    task automatic send_in_window(input logic [1:0] op, input logic value);
        logic [5:0] row, col;
        if ($urandom_range(0, 9) == 0) begin
            send_noise();
        end else begin
            pick_window_cell(row, col);
            send_command(op, row, col, value);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset at 64 x 64: grid clear, all four corners writable and readable,
    // clearing a cell, and the unused operation code.
    task automatic test_corner_cells();
        send_command(OP_READ, 6'd0, 6'd0, 1'b0);
        send_command(OP_READ, 6'd63, 6'd63, 1'b1);
        send_command(OP_WRITE, 6'd0, 6'd0, 1'b1);
        send_command(OP_WRITE, 6'd0, 6'd63, 1'b1);
        send_command(OP_WRITE, 6'd63, 6'd0, 1'b1);
        send_command(OP_WRITE, 6'd63, 6'd63, 1'b1);
        send_command(OP_READ, 6'd0, 6'd63, 1'b0);
        send_command(OP_READ, 6'd63, 6'd0, 1'b0);
        send_command(OP_WRITE, 6'd63, 6'd63, 1'b0);
        send_command(OP_READ, 6'd63, 6'd63, 1'b0);
        send_command(OP_UNUSED, 6'd63, 6'd63, 1'b1);
    endtask

    // Shrunk, zero and oversized grids. Cells left outside a small grid must
    // survive untouched and read back once the size grows again.
    task automatic test_size_limits();
        wait_idle();
        write_size(REG_GRID_ROWS, 7'd3);
        write_size(REG_GRID_COLUMNS, 7'd5);
        send_command(OP_WRITE, 6'd3, 6'd0, 1'b1);  // row just past the edge
        send_command(OP_READ, 6'd0, 6'd5, 1'b0);   // column just past the edge
        send_command(OP_READ, 6'd0, 6'd0, 1'b0);
        wait_idle();
        write_size(REG_GRID_ROWS, 7'd0);
        send_command(OP_READ, 6'd0, 6'd0, 1'b0);
        send_command(OP_ADVANCE, 6'd0, 6'd0, 1'b0);
        wait_idle();
        write_size(REG_GRID_ROWS, 7'd127);
        write_size(REG_GRID_COLUMNS, 7'd0);
        send_command(OP_ADVANCE, 6'd63, 6'd63, 1'b1);  // no columns: nothing may change
        wait_idle();
        write_size(REG_GRID_COLUMNS, 7'd127);
        send_command(OP_READ, 6'd0, 6'd63, 1'b1);
    endtask

    // Vertical blinker on a 5 x 5 grid next to the live corner cell.
    task automatic test_blinker();
        wait_idle();
        write_size(REG_GRID_ROWS, 7'd5);
        write_size(REG_GRID_COLUMNS, 7'd5);
        send_command(OP_WRITE, 6'd1, 6'd2, 1'b1);
        send_command(OP_WRITE, 6'd2, 6'd2, 1'b1);
        send_command(OP_WRITE, 6'd3, 6'd2, 1'b1);
        send_command(OP_ADVANCE, 6'd0, 6'd0, 1'b0);
        send_command(OP_READ, 6'd2, 6'd1, 1'b0);
        send_command(OP_READ, 6'd2, 6'd3, 1'b0);
        send_command(OP_READ, 6'd1, 6'd2, 1'b0);
    endtask

    // The receiver holds off for a long stretch while beats keep coming, so the
    // result register fills and the block has to stall its input.
    task automatic test_output_stall();
        hold_request = 1'b1;
        burst_left   = 40;
        repeat (24) begin
            send_command(2'($urandom_range(0, 1)), 6'($urandom_range(0, 4)),
                         6'($urandom_range(0, 6)), 1'($urandom));
        end
        send_command(OP_ADVANCE, 6'($urandom), 6'($urandom), 1'($urandom));
    endtask

    // Random phases: pick a size, seed a window with live cells, run a few
    // generations and read back around the window. Big grids get one generation
    // per phase since a full pass walks every row.
    task automatic test_random_generations();
        int               pick, rows, cols, gens;
        logic [CFG_W-1:0] new_rows, new_cols;
        while (commands_sent < COMMAND_TARGET) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                new_rows = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
                new_cols = (new_rows == 0) ? 7'($urandom_range(0, 127)) : 7'd0;
            end else if (pick == 1) begin
                new_rows = 7'($urandom_range(65, 127));
                new_cols = 7'($urandom_range(65, 127));
            end else if (pick <= 3) begin
                new_rows = 7'($urandom_range(17, 64));
                new_cols = 7'($urandom_range(1, 64));
            end else begin
                new_rows = 7'($urandom_range(1, 12));
                new_cols = ($urandom_range(0, 3) == 0) ? 7'd64 : 7'($urandom_range(1, 16));
            end
            wait_idle();
            write_size(REG_GRID_ROWS, new_rows);
            write_size(REG_GRID_COLUMNS, new_cols);
            rows = rows_in_use();
            cols = cols_in_use();

            if (rows == 0 || cols == 0) begin
                // empty grid: every access flagged, advance is a no-op
                repeat ($urandom_range(4, 10)) begin
                    if ($urandom_range(0, 3) == 0)
                        send_command(OP_ADVANCE, 6'($urandom), 6'($urandom), 1'($urandom));
                    else
                        send_noise();
                end
                continue;
            end

            // Window origin sits on a border two times in three, so edge cells see use.
            win_h = $urandom_range(3, 10);
            if (win_h > rows) win_h = rows;
            win_w = $urandom_range(3, 10);
            if (win_w > cols) win_w = cols;
            case ($urandom_range(0, 2))
                0:       win_r0 = 0;
                1:       win_r0 = rows - win_h;
                default: win_r0 = $urandom_range(0, rows - win_h);
            endcase
            case ($urandom_range(0, 2))
                0:       win_c0 = 0;
                1:       win_c0 = cols - win_w;
                default: win_c0 = $urandom_range(0, cols - win_w);
            endcase

            pick = $urandom_range(25, 65);  // seed density in percent
            repeat ($urandom_range(4, 20))
                send_in_window(OP_WRITE, $urandom_range(0, 99) < pick);

            gens = (rows > 16) ? 1 : $urandom_range(1, 5);
            repeat (gens) begin
                send_command(OP_ADVANCE, 6'($urandom), 6'($urandom), 1'($urandom));
                repeat ($urandom_range(2, 8)) send_in_window(OP_READ, 1'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Receiver pattern: runs of ready, short stalls, now and then a long clean
    // stretch, and the long hold-off when the pressure test asks for it.
    initial begin
        int   run_left, hold_left, pick;
        logic level;
        run_left  = 0;
        hold_left = 0;
        level     = 1'b1;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6) begin
                        level    = 1'b1;
                        run_left = $urandom_range(1, 30);
                    end else if (pick < 9) begin
                        level    = 1'b0;
                        run_left = $urandom_range(1, 6);
                    end else begin
                        level    = 1'b1;
                        run_left = $urandom_range(100, 300);
                    end
                end
                run_left--;
                i_out_ready <= level;
            end
        end
    end

    // Each result beat is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_cell_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_cell_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, %s %0b %0b",
                         $time, "actual cell_out/range_error", o_cell_out, o_range_error);
                failures++;
            end else begin
                want = pending_cell_results.pop_front();
                results_checked++;
                if (o_cell_out !== want.alive) begin
                    $display("%0t: cell_out mismatch, expected %0b, actual %0b",
                             $time, want.alive, o_cell_out);
                    failures++;
                end
                if (o_range_error !== want.flagged) begin
                    $display("%0t: range_error mismatch, expected %0b, actual %0b",
                             $time, want.flagged, o_range_error);
                    failures++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= REG_GRID_ROWS;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_operation    <= OP_WRITE;
        i_row_index    <= '0;
        i_column_index <= '0;
        i_cell_in      <= 1'b0;
        size_rows      = GRID_SIZE_RESET;
        size_columns   = GRID_SIZE_RESET;
        foreach (grid_model[r]) grid_model[r] = '0;
        failures         = 0;
        commands_sent    = 0;
        results_checked  = 0;
        generations_sent = 0;
        flagged_expected = 0;
        size_writes      = 0;
        burst_left       = 0;
        hold_request     = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_cells();
        test_size_limits();
        test_blinker();
        test_output_stall();
        test_random_generations();

        // drain, then give any stray beat time to show up
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d commands with %0d generation steps and %0d out-of-range accesses",
                 commands_sent, generations_sent, flagged_expected);
        $display("over %0d size register writes; %0d result beats compared",
                 size_writes, results_checked);
        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/lgg_pkg.sv
hw/rtl/lgg_ram.sv
hw/rtl/lgg_row_engine.sv
hw/rtl/life_grid_generation_step.sv
hw/rtl/lgg_checker.sv
tb/life_grid_generation_step_test.sv
